// File: hw/rtl/sab_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// Request/response payload structs and request/status codes.
// No dependencies.
package sab_pkg;

  // Fixed field widths of the request and response items
  localparam int REQ_TYPE_W = 2;
  localparam int INDEX_W    = 6;
  localparam int WDATA_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int RDATA_W    = 32;

  // Request codes; the fourth code carries no operation
  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_STORE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_DELETE = 2'd2
  } req_code_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_UNUSED = 2'd3
  } status_t;

  // Request item
  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [INDEX_W-1:0]    slot_index;
    logic [WDATA_W-1:0]    write_data;
  } req_t;

  // Response item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  result_index;
    logic [RDATA_W-1:0]  read_data;
  } rsp_t;

endpackage

// File: hw/rtl/sab_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
// Payload type is a parameter; used with the structs of sab_pkg.
interface sab_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sab_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; hold the last word when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/slot_allocator_bitmap_unit.sv
// Bitmap slot allocator top level: free bitmap, high-water mark, freed count.
// Depends on sab_pkg, sab_stream_if and sab_ram.
//
// Takes one request item per clock unless a held response is stalled, and returns
// exactly one response item per request. A store goes to the lowest freed slot
// below the high-water mark when deletions are pending, else to the slot at the
// high-water mark, which advances; with no room it answers STAT_FULL. Reads and
// deletes at or beyond the high-water mark answer STAT_RANGE, and of a free
// slot STAT_UNUSED. The rate is set by the combinational priority encoder over
// the CAPACITY-bit free bitmap and by the registered read port of the slot RAM,
// which delivers read data together with the response register.
// The response register lets a new request enter while a response is stalled
// only when that response leaves in the same cycle.
module slot_allocator_bitmap_unit #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  sab_stream_if.sink   req,
  sab_stream_if.source rsp
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int HW_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W  = sab_pkg::INDEX_W + 1;
  localparam int EXT_W  = (DATA_WIDTH > sab_pkg::WDATA_W) ? DATA_WIDTH : sab_pkg::WDATA_W;

  // Allocator state
  logic [CAPACITY-1:0] free_map;
  logic [CAPACITY-1:0] free_map_next;
  logic [HW_W-1:0]     high_water;
  logic [HW_W-1:0]     high_water_next;
  logic [HW_W-1:0]     freed_count;
  logic [HW_W-1:0]     freed_count_next;

  // Response register
  logic                            rsp_valid;
  sab_pkg::status_t                rsp_status;
  sab_pkg::status_t                rsp_status_next;
  logic [sab_pkg::INDEX_W-1:0]     rsp_index;
  logic [sab_pkg::INDEX_W-1:0]     rsp_index_next;
  logic                            rsp_read_hit;
  logic                            rsp_read_hit_next;

  // Request decode
  logic                            accept;
  logic [sab_pkg::INDEX_W-1:0]     idx;
  logic [SLOT_W-1:0]               idx_slot;
  logic                            in_range;
  logic                            slot_free;
  logic [CAPACITY-1:0]             cand;
  logic [SLOT_W-1:0]               pick_slot;
  logic                            found_freed;
  logic                            hw_room;

  // RAM ports
  logic                  ram_wr_en;
  logic [SLOT_W-1:0]     ram_wr_addr;
  logic [DATA_WIDTH-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [DATA_WIDTH-1:0] ram_rd_data;
  logic [EXT_W-1:0]      wdata_ext;
  logic [EXT_W-1:0]      rdata_ext;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;

  assign idx       = req.data.slot_index;
  assign idx_slot  = idx[SLOT_W-1:0];
  assign in_range  = CMP_W'(idx) < CMP_W'(high_water);
  assign slot_free = in_range ? free_map[idx_slot] : 1'b1;
  assign hw_room   = high_water < HW_W'(CAPACITY);

  // Mask the free bitmap to slots below the high-water mark
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cand[i] = free_map[i] && (HW_W'(i) < high_water);
    end
  end

  // Find the lowest freed slot
  always_comb begin
    pick_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_slot = SLOT_W'(i);
      end
    end
  end

  assign found_freed = (freed_count != '0) && (cand != '0);

  // Fit write data to the slot width and read data to the response width
  assign wdata_ext   = EXT_W'(req.data.write_data);
  assign ram_wr_data = wdata_ext[DATA_WIDTH-1:0];
  assign rdata_ext   = EXT_W'(ram_rd_data);

  // Work out the next state, RAM access and response for the offered request
  always_comb begin
    free_map_next     = free_map;
    high_water_next   = high_water;
    freed_count_next  = freed_count;
    rsp_status_next   = sab_pkg::STAT_OK;
    rsp_index_next    = idx;
    rsp_read_hit_next = 1'b0;
    ram_wr_en         = 1'b0;
    ram_wr_addr       = high_water[SLOT_W-1:0];
    ram_rd_en         = 1'b0;

    unique case (req.data.req_type)
      sab_pkg::REQ_STORE: begin
        if (found_freed) begin
          ram_wr_en                = accept;
          ram_wr_addr              = pick_slot;
          free_map_next[pick_slot] = 1'b0;
          freed_count_next         = freed_count - HW_W'(1);
          rsp_index_next           = sab_pkg::INDEX_W'(pick_slot);
        end else if (hw_room) begin
          ram_wr_en                = accept;
          ram_wr_addr              = high_water[SLOT_W-1:0];
          free_map_next[high_water[SLOT_W-1:0]] = 1'b0;
          high_water_next          = high_water + HW_W'(1);
          rsp_index_next           = sab_pkg::INDEX_W'(high_water);
        end else begin
          rsp_status_next = sab_pkg::STAT_FULL;
          rsp_index_next  = '0;
        end
      end
      sab_pkg::REQ_READ, sab_pkg::REQ_DELETE: begin
        if (!in_range) begin
          rsp_status_next = sab_pkg::STAT_RANGE;
        end else if (slot_free) begin
          rsp_status_next = sab_pkg::STAT_UNUSED;
        end else if (req.data.req_type == sab_pkg::REQ_READ) begin
          ram_rd_en         = accept;
          rsp_read_hit_next = 1'b1;
        end else begin
          free_map_next[idx_slot] = 1'b1;
          freed_count_next        = freed_count + HW_W'(1);
        end
      end
      default: begin
        // unused request code: answer ok with the requested index
        rsp_status_next = sab_pkg::STAT_OK;
      end
    endcase
  end

  // Update allocator state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      free_map    <= '1;
      high_water  <= '0;
      freed_count <= '0;
    end else if (accept) begin
      free_map    <= free_map_next;
      high_water  <= high_water_next;
      freed_count <= freed_count_next;
    end
  end

  // Hold the response until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req.ready) begin
      rsp_valid <= accept;
    end
  end

  // Capture response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status   <= rsp_status_next;
      rsp_index    <= rsp_index_next;
      rsp_read_hit <= rsp_read_hit_next;
    end
  end

  sab_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_slot),
    .rd_data (ram_rd_data)
  );

  // Drive the response channel
  assign rsp.valid             = rsp_valid;
  assign rsp.data.status       = rsp_status;
  assign rsp.data.result_index = rsp_index;
  assign rsp.data.read_data    = rsp_read_hit ? rdata_ext[sab_pkg::RDATA_W-1:0] : '0;

endmodule
